@@ hw/rtl/linear_recurrence_term_mod_defines.svh @@
// Assertion macros for the linear recurrence term block.
`ifndef LINEAR_RECURRENCE_TERM_MOD_DEFINES_SVH
`define LINEAR_RECURRENCE_TERM_MOD_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define LRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/lrt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_pkg
// Shared widths, constants and types of the linear recurrence term block.
// ---------------------------------------------------------------------------
package lrt_pkg;
  localparam int unsigned ValW        = 31;
  localparam int unsigned IndexBitsDef = 31;
  localparam logic [ValW-1:0] ModulusReset = 31'd1000000007;

  // Modular multiplier request
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [ValW-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] prod;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StWait,
    StFinal,
    StFinalWait,
    StDone
  } lrt_state_e;
endpackage

@@ hw/rtl/lrt_mulmod.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// double-and-add with a conditional subtract after each step.
// ---------------------------------------------------------------------------
module lrt_mulmod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrt_pkg::mm_req_t req_i,
  output lrt_pkg::mm_rsp_t rsp_o
);
  localparam int unsigned W  = lrt_pkg::ValW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  m_q, m_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W+1:0]  dbl, dbl_r, add, add_r;

  // Double, reduce, add the multiplicand, reduce
  always_comb begin
    dbl   = {2'b0, acc_q} << 1;
    dbl_r = (dbl >= {2'b0, m_q}) ? dbl - {2'b0, m_q} : dbl;
    add   = b_q[W-1] ? dbl_r + {2'b0, a_q} : dbl_r;
    add_r = (add >= {2'b0, m_q}) ? add - {2'b0, m_q} : add;
  end

  // Advance one bit per cycle
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // operand a is pre-reduced by the caller
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      m_d    = req_i.m;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = add_r[W-1:0];
      b_d   = b_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
endmodule

@@ hw/rtl/lrt_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_seq
// Square-and-multiply sequencer: walks the index bits, issues the matrix
// products to the shared multiplier and accumulates the sums.
// ---------------------------------------------------------------------------
module lrt_seq #(
  parameter int unsigned IndexBits = lrt_pkg::IndexBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [lrt_pkg::ValW-1:0] a_i,
  input  logic [lrt_pkg::ValW-1:0] b_i,
  input  logic [IndexBits-1:0]     n_i,
  input  logic [lrt_pkg::ValW-1:0] m_i,
  output lrt_pkg::mm_req_t         mm_req_o,
  input  lrt_pkg::mm_rsp_t         mm_rsp_i,
  output logic                     done_o,
  output logic [lrt_pkg::ValW-1:0] value_o
);
  localparam int unsigned W  = lrt_pkg::ValW;
  localparam int unsigned BW = (IndexBits > 1) ? $clog2(IndexBits) : 1;

  lrt_pkg::lrt_state_e state_q, state_d;
  logic [W-1:0] p_q [4];
  logic [W-1:0] q_q [4];
  logic [W-1:0] t_q [4];
  logic [W-1:0] m_q, a_q, b_q, acc_q;
  logic [IndexBits-1:0] n_q;
  logic [BW-1:0] bit_q;
  logic [2:0]    step_q;  // product 0..7 within one matrix product
  logic          ph_q;    // 0 multiply / 1 square
  logic [W:0]    sum;
  logic [W-1:0]  sum_r, opa, opb, one_v;
  logic [1:0]    ent;
  logic          last_bit, last_step;

  // Operand select: entry = step/2, product term = step%2
  always_comb begin
    ent = step_q[2:1];
    // x[row*2+k] * y[k*2+col], row=ent[1], col=ent[0], k=step_q[0]
    if (ph_q) begin
      opa = q_q[{ent[1], step_q[0]}];
    end else begin
      opa = p_q[{ent[1], step_q[0]}];
    end
    opb = q_q[{step_q[0], ent[0]}];
    // final pass: reduced matrix entry first, raw start term as serial operand
    if (state_q == lrt_pkg::StFinal || state_q == lrt_pkg::StFinalWait) begin
      opa = step_q[0] ? p_q[2] : p_q[0];
      opb = step_q[0] ? b_q : a_q;
    end
  end

  assign sum   = {1'b0, acc_q} + {1'b0, mm_rsp_i.prod};
  assign sum_r = (sum >= {1'b0, m_q}) ? W'(sum - {1'b0, m_q}) : sum[W-1:0];
  assign last_bit  = (bit_q == BW'(IndexBits - 1));
  assign last_step = (step_q == 3'd7);
  assign one_v     = (m_i == W'(1)) ? '0 : W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrt_pkg::StIdle:      if (go_i) state_d = lrt_pkg::StMul;
      lrt_pkg::StMul:       state_d = lrt_pkg::StWait;
      lrt_pkg::StWait: begin
        if (mm_rsp_i.done) begin
          if (ph_q && last_step && last_bit) state_d = lrt_pkg::StFinal;
          else                               state_d = lrt_pkg::StMul;
        end
      end
      lrt_pkg::StFinal:     state_d = lrt_pkg::StFinalWait;
      lrt_pkg::StFinalWait: begin
        if (mm_rsp_i.done && step_q[0]) state_d = lrt_pkg::StDone;
        else if (mm_rsp_i.done)         state_d = lrt_pkg::StFinal;
      end
      lrt_pkg::StDone:      state_d = lrt_pkg::StIdle;
      default:              state_d = lrt_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    mm_req_o.start = (state_q == lrt_pkg::StMul) || (state_q == lrt_pkg::StFinal);
    mm_req_o.a     = opa;
    mm_req_o.b     = opb;
    mm_req_o.m     = m_q;
    done_o         = (state_q == lrt_pkg::StDone);
    value_o        = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: matrices, index bits, accumulator
  always_ff @(posedge clk_i) begin
    case (state_q)
      lrt_pkg::StIdle: begin
        if (go_i) begin
          m_q <= m_i;
          // start terms stay unreduced; the final products reduce them
          a_q <= a_i;
          b_q <= b_i;
          n_q <= n_i;
          p_q[0] <= one_v; p_q[1] <= '0; p_q[2] <= '0; p_q[3] <= one_v;
          q_q[0] <= '0; q_q[1] <= one_v; q_q[2] <= one_v; q_q[3] <= one_v;
          bit_q  <= '0;
          step_q <= '0;
          ph_q   <= ~n_i[0];
          acc_q  <= '0;
        end
      end
      lrt_pkg::StWait: begin
        if (mm_rsp_i.done) begin
          if (step_q[0]) begin
            t_q[ent] <= sum_r;
            acc_q    <= '0;
          end else begin
            acc_q <= mm_rsp_i.prod;
          end
          step_q <= last_step ? '0 : step_q + 1'b1;
          if (last_step) begin
            if (ph_q) begin
              q_q[0] <= t_q[0]; q_q[1] <= t_q[1]; q_q[2] <= t_q[2]; q_q[3] <= sum_r;
              bit_q  <= bit_q + 1'b1;
              ph_q   <= last_bit ? 1'b1 : ~n_q[bit_q + 1'b1];
            end else begin
              p_q[0] <= t_q[0]; p_q[1] <= t_q[1]; p_q[2] <= t_q[2]; p_q[3] <= sum_r;
              ph_q   <= 1'b1;
            end
          end
        end
      end
      lrt_pkg::StFinalWait: begin
        if (mm_rsp_i.done) begin
          if (step_q[0]) acc_q <= sum_r;
          else           acc_q <= mm_rsp_i.prod;
          step_q <= step_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

@@ hw/rtl/linear_recurrence_term_mod.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_recurrence_term_mod
// Term n of a Fibonacci-like sequence modulo a configured modulus.
// ---------------------------------------------------------------------------
// Raise start while busy is low to hand in one beat. An index below two
// answers through the short_q and out_vld_q registers with the chosen start
// term, unreduced. Otherwise Q^n is formed by square-and-multiply over
// IndexBits index bits; each 2x2 product takes eight modular multiplies on
// one bit-serial multiplier, and busy stays high until the result. The result
// beat shows on term_value_o for exactly one cycle with valid_o high; the
// receiver cannot stall it. Write the modulus through cfg_wdata_i with
// cfg_we_i only while idle.
// ---------------------------------------------------------------------------
module linear_recurrence_term_mod #(
  parameter int unsigned IndexBits = lrt_pkg::IndexBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [lrt_pkg::ValW-1:0] first_term_i,
  input  logic [lrt_pkg::ValW-1:0] second_term_i,
  input  logic [lrt_pkg::ValW-1:0] term_index_i,
  input  logic                     cfg_we_i,
  input  logic [lrt_pkg::ValW-1:0] cfg_wdata_i,
  output logic                     valid_o,
  output logic [lrt_pkg::ValW-1:0] term_value_o
);
  localparam int unsigned W  = lrt_pkg::ValW;
  localparam int unsigned NW = (IndexBits < W) ? IndexBits : W;

  logic [W-1:0] mod_q, m_eff, a_red, b_red;
  logic [IndexBits-1:0] n_ext;
  logic        accept, short_idx, seq_done, seq_busy_q;
  logic        short_q;
  logic        out_vld_q;
  logic [W-1:0] out_q, short_val_q;
  lrt_pkg::mm_req_t mm_req;
  lrt_pkg::mm_rsp_t mm_rsp;
  logic [W-1:0] seq_val;

  assign accept    = start && !busy;
  assign n_ext     = IndexBits'(term_index_i[NW-1:0]);
  assign short_idx = (n_ext < IndexBits'(2));
  assign m_eff     = (mod_q == '0) ? W'(1) : mod_q;

  // Start terms go in unreduced; the multiplier takes them as its serial operand
  assign a_red = first_term_i;
  assign b_red = second_term_i;

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= lrt_pkg::ModulusReset;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  // Track busy and the short path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_busy_q <= 1'b0;
      short_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      short_q   <= accept && short_idx;
      out_vld_q <= short_q || seq_done;
      if (accept && !short_idx) seq_busy_q <= 1'b1;
      else if (seq_done)        seq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) short_val_q <= term_index_i[0] ? second_term_i : first_term_i;
    if (short_q)       out_q <= short_val_q;
    else if (seq_done) out_q <= seq_val;
  end

  assign busy         = seq_busy_q || short_q || out_vld_q;
  assign valid_o      = out_vld_q;
  assign term_value_o = out_q;

  lrt_seq #(.IndexBits(IndexBits)) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (accept && !short_idx),
    .a_i      (a_red),
    .b_i      (b_red),
    .n_i      (n_ext),
    .m_i      (m_eff),
    .mm_req_o (mm_req),
    .mm_rsp_i (mm_rsp),
    .done_o   (seq_done),
    .value_o  (seq_val)
  );

  lrt_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );
endmodule

@@ hw/rtl/lrt_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_checker
// Port-level checks of the linear recurrence term block.
// ---------------------------------------------------------------------------
`include "linear_recurrence_term_mod_defines.svh"
module lrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);
  // An accepted beat makes the block busy next cycle
  `LRT_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, start && !busy, busy)
  // A result beat lasts one cycle
  `LRT_ASSERT_NXT(a_vld_pulse, clk_i, rst_ni, valid_o, !valid_o)
  // No result beat while idle
  `LRT_ASSERT_IMP(a_vld_busy, clk_i, rst_ni, valid_o, busy)
endmodule

bind linear_recurrence_term_mod lrt_checker u_lrt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);
